>>> rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// shared types and constants for the triangle plane clipper
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int FRAC_W = 16;
	localparam int DIST_W = 32;
	localparam int BARY_W = FRAC_W + 1;
	localparam int MAG_W  = DIST_W + 1;

	typedef struct packed {
		logic signed [DIST_W-1:0] dist_0;
		logic signed [DIST_W-1:0] dist_1;
		logic signed [DIST_W-1:0] dist_2;
	} tri_in_t;

	typedef struct packed {
		logic [BARY_W-1:0] bary_a;
		logic [BARY_W-1:0] bary_b;
		logic [1:0]        vertex_number;
		logic              last_vertex;
	} vtx_out_t;

	// classified job from front to back
	typedef enum logic [1:0] {
		CASE_ALL  = 2'd0,
		CASE_ONE  = 2'd1,
		CASE_TWO  = 2'd2,
		CASE_NONE = 2'd3
	} clip_case_t;

	typedef struct packed {
		clip_case_t       kind;
		logic [1:0]       c_idx;
		logic [MAG_W-1:0] mag_c;
		logic [MAG_W-1:0] den_p;
		logic [MAG_W-1:0] den_n;
	} clip_job_t;

	localparam logic [1:0] VTX0 = 2'd0;
	localparam logic [1:0] VTX1 = 2'd1;
	localparam logic [1:0] VTX2 = 2'd2;

	function automatic logic [1:0] prev_idx(input logic [1:0] c);
		case (c)
			VTX0: prev_idx = VTX2;
			VTX1: prev_idx = VTX0;
			default: prev_idx = VTX1;
		endcase
	endfunction

	function automatic logic [1:0] next_idx(input logic [1:0] c);
		case (c)
			VTX0: next_idx = VTX1;
			VTX1: next_idx = VTX2;
			default: next_idx = VTX0;
		endcase
	endfunction

	function automatic logic corner_a(input logic [1:0] c);
		corner_a = (c == VTX0);
	endfunction

	function automatic logic corner_b(input logic [1:0] c);
		corner_b = (c == VTX1);
	endfunction

endpackage

>>> rtl/tpc_front.sv
// ----------------------------------------------------------------------------
// tpc_front
// classifies a triangle and forms magnitudes and edge denominators
// ----------------------------------------------------------------------------
module tpc_front import tpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  tri_in_t   in_data,
	output logic      job_valid,
	input  logic      job_stall,
	output clip_job_t job
);
	logic [MAG_W-1:0] mag [3];
	logic [2:0]       neg;
	logic [1:0]       nn_cnt;
	logic [1:0]       c_sel;
	logic [1:0]       p_sel;
	logic [1:0]       n_sel;
	clip_job_t        job_d;
	logic             v_s1;
	clip_job_t        job_s1;

	assign neg = {in_data.dist_2[DIST_W-1], in_data.dist_1[DIST_W-1],
		in_data.dist_0[DIST_W-1]};

	function automatic logic [MAG_W-1:0] absv(input logic signed [DIST_W-1:0] d);
		logic [MAG_W-1:0] x;
		x = {d[DIST_W-1], d};
		absv = d[DIST_W-1] ? (~x + 1'b1) : x;
	endfunction

	always_comb begin
		mag[0] = absv(in_data.dist_0);
		mag[1] = absv(in_data.dist_1);
		mag[2] = absv(in_data.dist_2);
		nn_cnt = 2'(!neg[0]) + 2'(!neg[1]) + 2'(!neg[2]);
		c_sel = VTX0;
		for (int i = 0; i < 3; i++) begin
			if (nn_cnt == 2'd1 && !neg[i]) c_sel = 2'(i);
			if (nn_cnt == 2'd2 && neg[i]) c_sel = 2'(i);
		end
		p_sel = prev_idx(c_sel);
		n_sel = next_idx(c_sel);
		case (nn_cnt)
			2'd3: job_d.kind = CASE_ALL;
			2'd2: job_d.kind = CASE_TWO;
			2'd1: job_d.kind = CASE_ONE;
			default: job_d.kind = CASE_NONE;
		endcase
		job_d.c_idx = c_sel;
		job_d.mag_c = mag[c_sel];
		job_d.den_p = mag[c_sel] + mag[p_sel];
		job_d.den_n = mag[c_sel] + mag[n_sel];
	end

	assign in_stall  = v_s1 && job_stall;
	assign job_valid = v_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) job_s1 <= job_d;
	end
endmodule

>>> rtl/tpc_queue.sv
// ----------------------------------------------------------------------------
// tpc_queue
// small job queue between front and back
// ----------------------------------------------------------------------------
module tpc_queue import tpc_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_stall,
	input  clip_job_t wr_data,
	output logic      rd_valid,
	input  logic      rd_stall,
	output clip_job_t rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	clip_job_t        mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;
	logic             wr_en;
	logic             rd_en;

	assign wr_stall = (cnt_q == (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign wr_en    = wr_valid && !wr_stall;
	assign rd_en    = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end
endmodule

>>> rtl/tpc_back.sv
// ----------------------------------------------------------------------------
// tpc_back
// two restoring dividers and vertex sequencer
// ----------------------------------------------------------------------------
module tpc_back import tpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_stall,
	input  clip_job_t job,
	output logic      out_valid,
	input  logic      out_stall,
	output vtx_out_t  out_data
);
	localparam int STEPS = FRAC_W + 1;
	localparam int SW    = $clog2(STEPS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} st_t;

	st_t              st_q;
	clip_case_t       kind_q;
	logic [1:0]       c_q;
	logic [MAG_W:0]   rp_q;
	logic [MAG_W:0]   rn_q;
	logic [MAG_W-1:0] dp_q;
	logic [MAG_W-1:0] dn_q;
	logic [BARY_W-1:0] tp_q;
	logic [BARY_W-1:0] tn_q;
	logic [SW-1:0]    step_q;
	logic [1:0]       k_q;
	logic [MAG_W:0]   rp_sh;
	logic [MAG_W:0]   rn_sh;
	logic             out_v_q;
	vtx_out_t         out_q;
	vtx_out_t         vtx;
	logic [1:0]       last_k;
	logic [1:0]       corner;
	logic             cross_p;
	logic             cross_n;
	logic             take;
	logic             emit;
	localparam logic [BARY_W-1:0] ONE = BARY_W'(1) << FRAC_W;

	function automatic logic [BARY_W-1:0] lerp(input logic c, input logic o,
		input logic [BARY_W-1:0] t);
		if (c == o) lerp = c ? ONE : '0;
		else lerp = c ? (ONE - t) : t;
	endfunction

	assign job_stall = (st_q != ST_IDLE);
	assign take      = job_valid && (st_q == ST_IDLE);
	assign rp_sh     = (step_q == '0) ? rp_q : {rp_q[MAG_W-1:0], 1'b0};
	assign rn_sh     = (step_q == '0) ? rn_q : {rn_q[MAG_W-1:0], 1'b0};
	assign last_k    = (kind_q == CASE_TWO) ? 2'd3 : 2'd2;
	assign emit      = (st_q == ST_EMIT) && (!out_v_q || !out_stall);

	always_comb begin
		corner  = c_q;
		cross_p = 1'b0;
		cross_n = 1'b0;
		case (kind_q)
			CASE_ONE: begin
				cross_p = (k_q == 2'd0);
				cross_n = (k_q == 2'd2);
			end
			CASE_TWO: begin
				cross_p = (k_q == 2'd1);
				cross_n = (k_q == 2'd2);
				corner  = (k_q == 2'd0) ? prev_idx(c_q) : next_idx(c_q);
			end
			default: corner = k_q;
		endcase
		if (cross_p) begin
			vtx.bary_a = lerp(corner_a(c_q), corner_a(prev_idx(c_q)), tp_q);
			vtx.bary_b = lerp(corner_b(c_q), corner_b(prev_idx(c_q)), tp_q);
		end else if (cross_n) begin
			vtx.bary_a = lerp(corner_a(c_q), corner_a(next_idx(c_q)), tn_q);
			vtx.bary_b = lerp(corner_b(c_q), corner_b(next_idx(c_q)), tn_q);
		end else begin
			vtx.bary_a = corner_a(corner) ? ONE : '0;
			vtx.bary_b = corner_b(corner) ? ONE : '0;
		end
		vtx.vertex_number = k_q;
		vtx.last_vertex   = (k_q == last_k);
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			out_v_q <= 1'b0;
			step_q  <= '0;
			k_q     <= '0;
		end else begin
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			if (emit) out_v_q <= 1'b1;
			case (st_q)
				ST_IDLE: begin
					if (take && job.kind != CASE_NONE) begin
						step_q <= '0;
						k_q    <= '0;
						st_q   <= (job.kind == CASE_ALL) ? ST_EMIT : ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == SW'(STEPS - 1)) st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						k_q <= k_q + 1'b1;
						if (k_q == last_k) st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= job.kind;
			c_q    <= job.c_idx;
			rp_q   <= {1'b0, job.mag_c};
			rn_q   <= {1'b0, job.mag_c};
			dp_q   <= job.den_p;
			dn_q   <= job.den_n;
			tp_q   <= '0;
			tn_q   <= '0;
		end else if (st_q == ST_DIV) begin
			if (rp_sh >= {1'b0, dp_q}) begin
				rp_q <= rp_sh - {1'b0, dp_q};
				tp_q <= {tp_q[BARY_W-2:0], 1'b1};
			end else begin
				rp_q <= rp_sh;
				tp_q <= {tp_q[BARY_W-2:0], 1'b0};
			end
			if (rn_sh >= {1'b0, dn_q}) begin
				rn_q <= rn_sh - {1'b0, dn_q};
				tn_q <= {tn_q[BARY_W-2:0], 1'b1};
			end else begin
				rn_q <= rn_sh;
				tn_q <= {tn_q[BARY_W-2:0], 1'b0};
			end
		end
		if (emit) out_q <= vtx;
	end
endmodule

>>> rtl/triangle_plane_clip_top.sv
// ----------------------------------------------------------------------------
// triangle_plane_clip_top
// clips a triangle against one plane, emits barycentric polygon vertices
// ----------------------------------------------------------------------------
// channel | direction | payload   | handshake
// in      | input     | tri_in_t  | in_valid / in_stall
// out     | output    | vtx_out_t | out_valid / out_stall
//
// a clipped triangle holds the back while it takes the job, runs the two parallel
// restoring dividers (one quotient bit per cycle) and then emits three or four
// vertices one by one as out_stall allows
// unclipped triangles skip the dividers, fully culled ones are dropped unemitted
// the front register and a 2-entry queue keep taking transactions while the back works
// reset clears all control state; out_stall holds the output register while out_valid is high
module triangle_plane_clip_top import tpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  tri_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output vtx_out_t out_data
);
	logic      f_valid;
	logic      f_stall;
	clip_job_t f_job;
	logic      b_valid;
	logic      b_stall;
	clip_job_t b_job;

	tpc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.job_valid(f_valid), .job_stall(f_stall), .job(f_job)
	);

	tpc_queue #(.DEPTH(2)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
		.rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_job)
	);

	tpc_back u_back (
		.clk, .arst_n, .job_valid(b_valid), .job_stall(b_stall), .job(b_job),
		.out_valid, .out_stall, .out_data
	);

	a_last_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_vertex |->
		(out_data.vertex_number == 2'd2 || out_data.vertex_number == 2'd3))
		else $error("last vertex at bad position");
	a_bary_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.bary_a + out_data.bary_b <= (BARY_W+1)'(1 << FRAC_W))
		else $error("barycentric sum above one");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid && out_stall) |-> out_valid && $stable(out_data))
		else $error("stalled output changed");
endmodule
